// File: sv/csb_pkg.sv
// Shared types and constants for the clipped sprite blit frame unit.
// No dependencies.
package csb_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  localparam int unsigned MaxWidthDef  = 240;
  localparam int unsigned MaxHeightDef = 240;

  localparam int DimW   = 8;
  localparam int CoordW = 16;
  localparam int ColorW = 16;
  localparam int CfgAw  = 3;
  localparam int CfgDw  = 32;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  localparam logic [DimW-1:0] DimReset = 8'd240;

endpackage

// File: sv/csb_frame_store.sv
// Frame store: one write port, one registered read port.
// Standalone; sized by the top level.
module csb_frame_store #(
  parameter int unsigned DEPTH = 57600,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/clipped_sprite_blit_frame_unit.sv
// Top level of the clipped sprite blit frame unit.
// Depends on csb_pkg and csb_frame_store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries commands: start frame with
//   sprite geometry, sprite pixel, read next frame pixel. Output channel
//   (out_valid_o/out_ready_i) carries one pixel per read command, with
//   last_pixel_o set on the final pixel of the width by height readout.
//   display_width (0x0) and display_height (0x4) are written over APB.
// Timing:
//   Sprite pixels are taken one per cycle outside a clear; the store write
//   lands in the next cycle. Reads are taken one per cycle unless held back
//   (see Stall); a result appears the cycle after acceptance, straight from
//   the store's registered read port. A read right after a sprite pixel waits
//   for that write to land. A start frame clears the store, one entry per
//   cycle over MAX_WIDTH*MAX_HEIGHT entries (57600 by default); in_ready_o is low.
// Reset: the same clearing pass runs after reset; registers go to 240.
// Stall: while a result waits on out_ready_i, sprite and start transactions
//   are still taken; further reads wait until the result is taken.
module clipped_sprite_blit_frame_unit
  import csb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [CoordW-1:0] sprite_cols_i,
  input  logic [CoordW-1:0] sprite_rows_i,
  input  logic [ColorW-1:0] color_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ColorW-1:0] pixel_o,
  output logic              last_pixel_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CfgAw-1:0]  paddr,
  input  logic [CfgDw-1:0]  pwdata,
  output logic [CfgDw-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  // configuration
  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w_act, h_act;
  logic [15:0]     total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegWidth:  width_q  <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWidth:  prdata = {{(CfgDw-DimW){1'b0}}, width_q};
      RegHeight: prdata = {{(CfgDw-DimW){1'b0}}, height_q};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    if (width_q == '0)                w_act = DimW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_act = DimW'(MAX_WIDTH);
    else                              w_act = width_q;
    if (height_q == '0)                 h_act = DimW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_act = DimW'(MAX_HEIGHT);
    else                                h_act = height_q;
  end

  assign total = w_act * h_act;

  // control state
  logic              clr_busy_q;
  logic [AW-1:0]     clr_addr_q;
  logic [CoordW-1:0] origin_x_q, origin_y_q, span_cols_q, span_rows_q;
  logic [CoordW-1:0] col_count_q, row_count_q, read_index_q;
  logic              wr_valid_q;
  logic [DimW-1:0]   wr_px_q, wr_py_q;
  logic [ColorW-1:0] wr_color_q;
  logic              out_valid_q, last_q;

  logic in_fire, is_start, is_pixel, is_read, read_ok;

  assign is_start = (command_i == CMD_START);
  assign is_pixel = (command_i == CMD_PIXEL);
  assign is_read  = (command_i == CMD_READ);
  assign read_ok  = !wr_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!is_read || read_ok);
  assign in_fire  = in_valid_i && in_ready_o;

  // sprite pixel placement
  logic [CoordW:0]   px_sum, py_sum, col_inc;
  logic              pix_live, pix_inside;

  assign px_sum     = {1'b0, origin_x_q} + {1'b0, col_count_q};
  assign py_sum     = {1'b0, origin_y_q} + {1'b0, row_count_q};
  assign pix_live   = (span_cols_q != '0) && (row_count_q < span_rows_q);
  assign pix_inside = (px_sum < (CoordW+1)'(w_act)) && (py_sum < (CoordW+1)'(h_act));
  assign col_inc    = {1'b0, col_count_q} + 17'd1;

  // readout index
  logic [15:0] rd_idx;
  logic [16:0] rd_inc;
  logic [15:0] rd_next;

  assign rd_idx  = (read_index_q >= total) ? 16'd0 : read_index_q;
  assign rd_inc  = {1'b0, rd_idx} + 17'd1;
  assign rd_next = (rd_inc >= {1'b0, total}) ? 16'd0 : rd_inc[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      span_cols_q  <= '0;
      span_rows_q  <= '0;
      col_count_q  <= '0;
      row_count_q  <= '0;
      read_index_q <= '0;
      wr_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      wr_valid_q <= in_fire && is_pixel && pix_live && pix_inside;
      if (in_fire && is_read) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_fire) begin
        if (is_start) begin
          clr_busy_q   <= 1'b1;
          clr_addr_q   <= '0;
          origin_x_q   <= pos_x_i;
          origin_y_q   <= pos_y_i;
          span_cols_q  <= sprite_cols_i;
          span_rows_q  <= sprite_rows_i;
          col_count_q  <= '0;
          row_count_q  <= '0;
          read_index_q <= '0;
        end else if (is_pixel) begin
          if (pix_live) begin
            if (col_inc >= {1'b0, span_cols_q}) begin
              col_count_q <= '0;
              row_count_q <= row_count_q + 16'd1;
            end else begin
              col_count_q <= col_inc[CoordW-1:0];
            end
          end
        end else if (is_read) begin
          read_index_q <= rd_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_pixel) begin
      wr_px_q    <= px_sum[DimW-1:0];
      wr_py_q    <= py_sum[DimW-1:0];
      wr_color_q <= color_i;
    end
    if (in_fire && is_read) begin
      last_q <= (rd_idx == total - 16'd1);
    end
  end

  // frame store ports
  logic [15:0]       wr_addr;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [ColorW-1:0] st_wdata;

  assign wr_addr  = 16'(wr_py_q * w_act) + {8'b0, wr_px_q};
  assign st_we    = clr_busy_q || wr_valid_q;
  assign st_waddr = clr_busy_q ? clr_addr_q : AW'(wr_addr);
  assign st_wdata = clr_busy_q ? '0 : wr_color_q;

  csb_frame_store #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (ColorW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (in_fire && is_read),
    .raddr_i(AW'(rd_idx)),
    .rdata_o(pixel_o)
  );

  assign out_valid_o  = out_valid_q;
  assign last_pixel_o = last_q;

endmodule

// File: sv/csb_checker.sv
// Port-level checks for the clipped sprite blit frame unit, bound to the top.
// Depends on csb_pkg.
module csb_checker
  import csb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        command_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ColorW-1:0] pixel_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_o))
    else $error("result changed while stalled");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_READ) |=> out_valid_o)
    else $error("read transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i != CMD_READ) && !out_valid_o |=> !out_valid_o)
    else $error("result without read transaction");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_START) |=> !in_ready_o)
    else $error("input taken during frame clear");

endmodule

bind clipped_sprite_blit_frame_unit csb_checker u_csb_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for clipped_sprite_blit_frame_unit: directed table, then random phases.
// Readout pixels are checked against an in-bench model of the frame store and sprite clipping.
// Depends on csb_pkg and the RTL of clipped_sprite_blit_frame_unit.
`timescale 1ns / 1ps

module tb;
  import csb_pkg::*;

  localparam int unsigned StoreDepth = MaxWidthDef * MaxHeightDef;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam logic [1:0]  CmdNone    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] cols;
    logic [CoordW-1:0] rows;
    logic [ColorW-1:0] color;
  } blit_item_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel;
    logic              last;
  } rd_pix_t;

  typedef enum {ROW_ITEM, ROW_SET_W, ROW_SET_H} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    blit_item_t        it;
    logic [DimW-1:0]   val;
    bit                chk;
    rd_pix_t           want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        command_i;
  logic [CoordW-1:0] pos_x_i;
  logic [CoordW-1:0] pos_y_i;
  logic [CoordW-1:0] sprite_cols_i;
  logic [CoordW-1:0] sprite_rows_i;
  logic [ColorW-1:0] color_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b1;
  logic [ColorW-1:0] pixel_o;
  logic              last_pixel_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CfgAw-1:0]  paddr;
  logic [CfgDw-1:0]  pwdata;
  logic [CfgDw-1:0]  prdata;
  logic              pready;

  // model state
  logic [ColorW-1:0] frame_mem [StoreDepth];
  logic [DimW-1:0]   width_reg;
  logic [DimW-1:0]   height_reg;
  int unsigned       org_x, org_y, span_c, span_r, col_n, row_n, rd_idx;

  rd_pix_t           pix_q [$];
  dir_row_t          dir_tab [$];
  int unsigned       mismatches = 0;
  int unsigned       idle_pct = 25;
  int unsigned       stall_left = 0;

  clipped_sprite_blit_frame_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .sprite_cols_i (sprite_cols_i),
    .sprite_rows_i (sprite_rows_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_o       (pixel_o),
    .last_pixel_o  (last_pixel_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned active_dim(input logic [DimW-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic report_bad(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  task automatic blit_step(input blit_item_t it, output bit has_res, output rd_pix_t res);
    int unsigned w, h, px, py, total, idx;
    has_res = 1'b0;
    res = '0;
    w = active_dim(width_reg, MaxWidthDef);
    h = active_dim(height_reg, MaxHeightDef);
    case (it.cmd)
      CMD_START: begin
        foreach (frame_mem[i]) frame_mem[i] = '0;
        org_x = it.pos_x;
        org_y = it.pos_y;
        span_c = it.cols;
        span_r = it.rows;
        col_n = 0;
        row_n = 0;
        rd_idx = 0;
      end
      CMD_PIXEL: begin
        if (span_c != 0 && row_n < span_r) begin
          px = org_x + col_n;
          py = org_y + row_n;
          if (px < w && py < h && py * w + px < StoreDepth) frame_mem[py * w + px] = it.color;
          col_n++;
          if (col_n >= span_c) begin
            col_n = 0;
            row_n++;
          end
        end
      end
      CMD_READ: begin
        total = w * h;
        idx = rd_idx;
        if (idx >= total || idx >= StoreDepth) idx = 0;
        res.pixel = frame_mem[idx];
        res.last = (idx == total - 1);
        has_res = 1'b1;
        idx++;
        if (idx >= total) idx = 0;
        rd_idx = idx;
      end
      default: ;
    endcase
  endtask

  // valid stays high after acceptance; the caller either sends again or lowers it
  task automatic send(input blit_item_t it, input bit chk, input rd_pix_t want);
    bit has_res;
    rd_pix_t pred;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= it.cmd;
    pos_x_i       <= it.pos_x;
    pos_y_i       <= it.pos_y;
    sprite_cols_i <= it.cols;
    sprite_rows_i <= it.rows;
    color_i       <= it.color;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    blit_step(it, has_res, pred);
    if (has_res) pix_q.push_back(chk ? want : pred);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pix_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [DimW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CfgDw'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegWidth) width_reg = val;
    else height_reg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[DimW-1:0] !== val) report_bad("register readback", val, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic dir_row_t xfer(input logic [1:0] cmd, input logic [15:0] x, y, c, r, color);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.it = '{cmd: cmd, pos_x: x, pos_y: y, cols: c, rows: r, color: color};
    row.val = '0;
    row.chk = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t read_chk(input logic [ColorW-1:0] pixel, input logic last);
    dir_row_t row;
    row = xfer(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    row.chk = 1'b1;
    row.want = '{pixel: pixel, last: last};
    return row;
  endfunction

  function automatic dir_row_t cfg(input row_kind_e kind, input logic [DimW-1:0] val);
    dir_row_t row;
    row = xfer(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    row.kind = kind;
    row.val = val;
    return row;
  endfunction

  function automatic logic [CoordW-1:0] pick_origin(input int unsigned dim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CoordW'($urandom);
    if (r < 55) return CoordW'($urandom_range(0, 6));
    return CoordW'($urandom_range(dim > 3 ? dim - 3 : 0, dim + 2));
  endfunction

  // random receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 399) < idle_pct) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : readout_check
    rd_pix_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pix_q.size() == 0) begin
        report_bad("unexpected result pixel", 32'h0, pixel_o);
      end else begin
        want = pix_q.pop_front();
        if (pixel_o !== want.pixel) report_bad("pixel", want.pixel, pixel_o);
        if (last_pixel_o !== want.last) report_bad("last_pixel", want.last, last_pixel_o);
      end
    end
  end

  initial begin : stim
    blit_item_t  it;
    rd_pix_t     none;
    int unsigned w, h, r, pix_left, n_items;
    int unsigned ph_w [9];
    int unsigned ph_h [9];
    int unsigned ph_idle [9];
    bit          ph_start [9];

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_READ;
    pos_x_i = '0;
    pos_y_i = '0;
    sprite_cols_i = '0;
    sprite_rows_i = '0;
    color_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    width_reg = DimReset;
    height_reg = DimReset;
    org_x = 0; org_y = 0; span_c = 0; span_r = 0; col_n = 0; row_n = 0; rd_idx = 0;
    none = '0;
    pix_left = 0;

    ph_w = '{3, 0, 16, 5, 8, 255, 1, 240, 0};
    ph_h = '{2, 5, 12, 0, 8, 1, 255, 240, 0};
    ph_idle = '{25, 0, 30, 20, 25, 0, 30, 20, 0};
    ph_start = '{1, 1, 1, 0, 1, 1, 0, 1, 1};

    dir_tab.push_back(read_chk(16'h0000, 1'b0));
    dir_tab.push_back(cfg(ROW_SET_W, 8'd0));
    dir_tab.push_back(cfg(ROW_SET_H, 8'd0));
    dir_tab.push_back(read_chk(16'h0000, 1'b1));
    dir_tab.push_back(xfer(CmdNone, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // origin at the top of the coordinate range: clipped, never wrapped
    dir_tab.push_back(xfer(CMD_START, 16'hFFFF, 16'h0000, 16'd2, 16'd1, 16'h0000));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    dir_tab.push_back(read_chk(16'h0000, 1'b1));
    dir_tab.push_back(cfg(ROW_SET_W, 8'd4));
    dir_tab.push_back(cfg(ROW_SET_H, 8'd3));
    dir_tab.push_back(xfer(CMD_START, 16'd1, 16'd1, 16'd4, 16'd2, 16'h0000));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hF800));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h07E0));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h001F));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7BEF));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1234));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hDEAD));
    repeat (4) dir_tab.push_back(xfer(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    dir_tab.push_back(cfg(ROW_SET_W, 8'd255));
    dir_tab.push_back(cfg(ROW_SET_H, 8'd255));
    dir_tab.push_back(xfer(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    // zero-width sprite: every pixel is dropped
    dir_tab.push_back(xfer(CMD_START, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h0000));
    dir_tab.push_back(xfer(CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    dir_tab.push_back(read_chk(16'h0000, 1'b0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_ITEM: send(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].want);
        ROW_SET_W: begin
          settle();
          set_reg(RegWidth, dir_tab[i].val);
        end
        default: begin
          settle();
          set_reg(RegHeight, dir_tab[i].val);
        end
      endcase
    end

    for (int p = 0; p < 9; p++) begin
      settle();
      if (p == 8) begin
        ph_w[p] = $urandom_range(1, 24);
        ph_h[p] = $urandom_range(1, 24);
      end
      set_reg(RegWidth, DimW'(ph_w[p]));
      set_reg(RegHeight, DimW'(ph_h[p]));
      idle_pct = ph_idle[p];
      w = active_dim(width_reg, MaxWidthDef);
      h = active_dim(height_reg, MaxHeightDef);
      n_items = 72;
      if (ph_start[p]) begin
        it.cmd = CMD_START;
        it.pos_x = pick_origin(w);
        it.pos_y = pick_origin(h);
        it.color = CoordW'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          it.cols = '0;
          it.rows = CoordW'($urandom);
        end else if (r < 16) begin
          it.cols = CoordW'($urandom);
          it.rows = CoordW'($urandom);
        end else begin
          it.cols = CoordW'($urandom_range(1, w + 3 < 10 ? w + 3 : 10));
          it.rows = CoordW'($urandom_range(1, h + 2 < 8 ? h + 2 : 8));
        end
        pix_left = it.cols * it.rows;
        send(it, 1'b0, none);
        n_items--;
      end
      for (int k = 0; k < n_items; k++) begin
        it.pos_x = CoordW'($urandom);
        it.pos_y = CoordW'($urandom);
        it.cols = CoordW'($urandom);
        it.rows = CoordW'($urandom);
        it.color = ColorW'($urandom);
        r = $urandom_range(0, 99);
        if (k == n_items - 1) begin
          it.cmd = CMD_READ;
        end else if (r < 4) begin
          it.cmd = CmdNone;
        end else if (pix_left > 0 ? r < 74 : r < 19) begin
          it.cmd = CMD_PIXEL;
          if (pix_left > 0) pix_left--;
        end else begin
          it.cmd = CMD_READ;
        end
        send(it, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    while (pix_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pix_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
